@@ sv/kpf_pkg.sv @@
package kpf_pkg;

    localparam int POS_W      = 32;
    localparam int COV_FRAC   = 30;
    localparam int COV_W      = COV_FRAC + 2;
    localparam int NOISE_W    = 31;
    localparam int MUL_W      = (COV_W > POS_W) ? COV_W : POS_W;
    localparam int ACC_W      = 2 * MUL_W + 1;
    localparam int DVD_W      = ACC_W;
    localparam int DVS_W      = ACC_W - COV_FRAC;
    localparam int CM_PER_M   = 100;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);

    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [COV_W-1:0]   cov_t;
    typedef logic signed [MUL_W-1:0]   mul_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic        [NOISE_W-1:0] noise_t;

    // floor(x / 100) as ((x >> 2) * ceil(2^35 / 25)) >> 35 for x below 2^32
    localparam int   VIS_PRE_SHIFT = 2;
    localparam int   VIS_SHIFT     = 35;
    localparam mul_t VIS_RECIP     = mul_t'(32'sh51eb851f);

    localparam noise_t QN_RESET =
        NOISE_W'(((64'd1 << COV_FRAC) + 64'd50) / 64'd100);
    localparam noise_t RN_RESET =
        NOISE_W'(((64'd1 << COV_FRAC) + 64'd200) / 64'd400);

    localparam cov_t COV_ONE   = cov_t'(1) <<< COV_FRAC;
    localparam cov_t COV_MAX   = {1'b0, {(COV_W-1){1'b1}}};
    localparam acc_t COV_MAX_A = (acc_t'(1) <<< (COV_W - 1)) - acc_t'(1);
    localparam acc_t POS_MAX_A = (acc_t'(1) <<< (POS_W - 1)) - acc_t'(1);
    localparam acc_t HALF_LSB  = acc_t'(1) <<< (COV_FRAC - 1);

    typedef struct packed {
        pos_t uwb_x;
        pos_t uwb_y;
        pos_t vision_x_cm;
        pos_t vision_y_cm;
    } in_word_t;

    typedef struct packed {
        pos_t fused_x;
        pos_t fused_y;
        logic singular;
    } out_word_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    function automatic cov_t sat_cov(acc_t v);
        if (v > COV_MAX_A) begin
            return COV_MAX;
        end else if (v < -COV_MAX_A) begin
            return -COV_MAX;
        end
        return v[COV_W-1:0];
    endfunction

    function automatic pos_t sat_pos_sym(acc_t v);
        if (v > POS_MAX_A) begin
            return POS_MAX_A[POS_W-1:0];
        end else if (v < -POS_MAX_A) begin
            return -(POS_MAX_A[POS_W-1:0]);
        end
        return v[POS_W-1:0];
    endfunction

    function automatic pos_t sat_pos(acc_t v);
        if (v > POS_MAX_A) begin
            return POS_MAX_A[POS_W-1:0];
        end else if (v < -POS_MAX_A - acc_t'(1)) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end
        return v[POS_W-1:0];
    endfunction

endpackage

@@ sv/kpf_mul.sv @@
module kpf_mul (
    input  logic          aclk,
    input  kpf_pkg::mul_t a,
    input  kpf_pkg::mul_t b,
    output kpf_pkg::acc_t p
);

    logic signed [2*kpf_pkg::MUL_W-1:0] prod;
    kpf_pkg::acc_t                      p_reg;

    always_comb begin
        prod = a * b;
    end

    always_ff @(posedge aclk) begin
        p_reg <= {prod[2*kpf_pkg::MUL_W-1], prod};
    end

    assign p = p_reg;

endmodule

@@ sv/kpf_div.sv @@
module kpf_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  kpf_pkg::div_req_t         req,
    output logic                      done,
    output logic [kpf_pkg::DVD_W-1:0] quot
);

    localparam int CNT_W = $clog2(kpf_pkg::DVD_W + 1);

    logic [kpf_pkg::DVD_W-1:0] dvd_reg, dvd_next;
    logic [kpf_pkg::DVS_W-1:0] dvs_reg;
    logic [kpf_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [kpf_pkg::DVS_W:0]   shifted;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic                      fits;

    always_comb begin
        shifted  = {rem_reg, dvd_reg[kpf_pkg::DVD_W-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? kpf_pkg::DVS_W'(shifted - {1'b0, dvs_reg})
                        : shifted[kpf_pkg::DVS_W-1:0];
        dvd_next = {dvd_reg[kpf_pkg::DVD_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && !req.start && (cnt_reg == CNT_W'(1));
            if (req.start) begin
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(kpf_pkg::DVD_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = dvd_reg;

endmodule

@@ sv/kalman_position_fusion_2d.sv @@
// 2-d kalman position fusion: each input word (uwb fix in metres, vision fix in
// centimetres, q16.16) yields one output word with the fused position and a
// singular flag; on a zero determinant the estimate and covariance are held.
// one word is in flight at a time; after the noise and measurement setup states a
// word uses two reciprocal products for the centimetre conversions, eleven
// two-term products on the shared 32x32 multiplier and four passes through the
// bit-serial divider for the gain entries. a zero determinant ends the word before
// the gain entries. a word not yet taken on the output stalls the next one. the
// noise registers are to be written on the cfg port only while idle; the block
// does not enforce it.
module kalman_position_fusion_2d (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  kpf_pkg::in_word_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output kpf_pkg::out_word_t             m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kpf_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_NOISE, ST_MEAS, ST_VIS, ST_DIV, ST_MAC, ST_POST, ST_INN, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        J_DET = 4'd0, J_VX = 4'd2,
        J_K0 = 4'd4, J_K1 = 4'd5, J_K2 = 4'd6, J_K3 = 4'd7,
        J_C0 = 4'd8, J_C1 = 4'd9,
        J_P0 = 4'd12, J_P1 = 4'd13, J_P2 = 4'd14, J_P3 = 4'd15
    } job_t;

    state_t                      state_reg;
    job_t                        job_reg;
    logic [1:0]                  term_reg;
    kpf_pkg::cov_t               cov_reg [4];
    kpf_pkg::pos_t               est_reg [2];
    kpf_pkg::noise_t             qn_reg, rn_reg;
    kpf_pkg::pos_t               pred_reg [2];
    kpf_pkg::pos_t               vis_reg [2];
    kpf_pkg::pos_t               z_reg [2];
    kpf_pkg::pos_t               inn_reg [2];
    kpf_pkg::pos_t               fx_reg [2];
    kpf_pkg::cov_t               pp_reg [4];
    kpf_pkg::cov_t               s_reg [4];
    kpf_pkg::cov_t               k_reg [4];
    kpf_pkg::cov_t               pn_reg [4];
    kpf_pkg::acc_t               acc_reg;
    logic signed [kpf_pkg::DVS_W-1:0] detf_reg;
    logic                        neg_reg;
    logic                        sing_reg;
    kpf_pkg::div_req_t           div_req_reg;
    kpf_pkg::out_word_t          out_reg;
    logic                        m_valid_reg;

    kpf_pkg::mul_t               mul_a, mul_b;
    kpf_pkg::acc_t               prod;
    logic                        div_done;
    logic [kpf_pkg::DVD_W-1:0]   div_quot;

    logic [1:0]                  sel;
    logic signed [kpf_pkg::DVS_W-1:0] detf_w;
    logic [kpf_pkg::DVD_W-1:0]   acc_mag;
    logic [kpf_pkg::DVS_W-1:0]   det_mag;
    kpf_pkg::acc_t               rnd_w;
    kpf_pkg::cov_t               q_cov;
    kpf_pkg::pos_t               q_vis;
    logic [kpf_pkg::DVD_W-1:0]   vis_mag;
    kpf_pkg::pos_t               vis_sel;
    logic                        div_go;

    kpf_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    kpf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // operand select for the two product terms of each job
    always_comb begin
        sel   = job_reg[1:0];
        mul_a = '0;
        mul_b = '0;
        case (job_reg)
            J_DET: begin
                mul_a = kpf_pkg::mul_t'(term_reg[0] ? s_reg[1] : s_reg[0]);
                mul_b = kpf_pkg::mul_t'(term_reg[0] ? s_reg[2] : s_reg[3]);
            end
            J_VX: begin
                mul_a = kpf_pkg::mul_t'((vis_mag + kpf_pkg::DVD_W'(kpf_pkg::CM_PER_M / 2))
                        >> kpf_pkg::VIS_PRE_SHIFT);
                mul_b = kpf_pkg::VIS_RECIP;
            end
            J_K0, J_K1, J_K2, J_K3: begin
                mul_a = kpf_pkg::mul_t'(pp_reg[{sel[1], term_reg[0]}]);
                if (!term_reg[0]) begin
                    mul_b = kpf_pkg::mul_t'(sel[0] ? -s_reg[1] : s_reg[3]);
                end else begin
                    mul_b = kpf_pkg::mul_t'(sel[0] ? s_reg[0] : -s_reg[2]);
                end
            end
            J_C0, J_C1: begin
                mul_a = kpf_pkg::mul_t'(k_reg[{sel[0], term_reg[0]}]);
                mul_b = kpf_pkg::mul_t'(inn_reg[term_reg[0]]);
            end
            J_P0, J_P1, J_P2, J_P3: begin
                mul_a = kpf_pkg::mul_t'(k_reg[{sel[1], term_reg[0]}]);
                mul_b = kpf_pkg::mul_t'(pp_reg[{term_reg[0], sel[0]}]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        detf_w  = kpf_pkg::DVS_W'(acc_reg >>> kpf_pkg::COV_FRAC);
        acc_mag = acc_reg[kpf_pkg::ACC_W-1] ? kpf_pkg::DVD_W'(-acc_reg)
                                            : kpf_pkg::DVD_W'(acc_reg);
        det_mag = detf_reg[kpf_pkg::DVS_W-1] ? kpf_pkg::DVS_W'(-detf_reg)
                                             : kpf_pkg::DVS_W'(detf_reg);
        rnd_w   = (acc_reg + kpf_pkg::HALF_LSB) >>> kpf_pkg::COV_FRAC;
        if (div_quot > kpf_pkg::DVD_W'(kpf_pkg::COV_MAX)) begin
            q_cov = kpf_pkg::COV_MAX;
        end else begin
            q_cov = div_quot[kpf_pkg::COV_W-1:0];
        end
        q_vis   = kpf_pkg::pos_t'(prod >>> kpf_pkg::VIS_SHIFT);
        vis_sel = term_reg[0] ? vis_reg[1] : vis_reg[0];
        vis_mag = vis_sel[kpf_pkg::POS_W-1]
                ? kpf_pkg::DVD_W'(-kpf_pkg::acc_t'(vis_sel))
                : kpf_pkg::DVD_W'(kpf_pkg::acc_t'(vis_sel));
        div_go  = (state_reg == ST_POST) && (job_reg == J_K0 || job_reg == J_K1 ||
                                             job_reg == J_K2 || job_reg == J_K3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_valid_reg       <= 1'b0;
            div_req_reg.start <= 1'b0;
            qn_reg            <= kpf_pkg::QN_RESET;
            rn_reg            <= kpf_pkg::RN_RESET;
            est_reg[0]        <= '0;
            est_reg[1]        <= '0;
            cov_reg[0]        <= kpf_pkg::COV_ONE;
            cov_reg[1]        <= '0;
            cov_reg[2]        <= '0;
            cov_reg[3]        <= kpf_pkg::COV_ONE;
        end else begin
            div_req_reg.start <= div_go;
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == kpf_pkg::REG_PROCESS_NOISE) begin
                    qn_reg <= cfg_data[kpf_pkg::NOISE_W-1:0];
                end else if (cfg_index == kpf_pkg::REG_MEASURE_NOISE) begin
                    rn_reg <= cfg_data[kpf_pkg::NOISE_W-1:0];
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        pred_reg[0] <= s_data.uwb_x;
                        pred_reg[1] <= s_data.uwb_y;
                        vis_reg[0]  <= s_data.vision_x_cm;
                        vis_reg[1]  <= s_data.vision_y_cm;
                        state_reg   <= ST_NOISE;
                    end
                end
                ST_NOISE: begin
                    pp_reg[0] <= kpf_pkg::sat_cov(kpf_pkg::acc_t'(cov_reg[0])
                                 + kpf_pkg::acc_t'(qn_reg));
                    pp_reg[1] <= cov_reg[1];
                    pp_reg[2] <= cov_reg[2];
                    pp_reg[3] <= kpf_pkg::sat_cov(kpf_pkg::acc_t'(cov_reg[3])
                                 + kpf_pkg::acc_t'(qn_reg));
                    state_reg <= ST_MEAS;
                end
                ST_MEAS: begin
                    s_reg[0]  <= kpf_pkg::sat_cov(kpf_pkg::acc_t'(pp_reg[0])
                                 + kpf_pkg::acc_t'(rn_reg));
                    s_reg[1]  <= pp_reg[1];
                    s_reg[2]  <= pp_reg[2];
                    s_reg[3]  <= kpf_pkg::sat_cov(kpf_pkg::acc_t'(pp_reg[3])
                                 + kpf_pkg::acc_t'(rn_reg));
                    job_reg   <= J_VX;
                    term_reg  <= 2'd0;
                    state_reg <= ST_VIS;
                end
                // centimetres to metres, x product then y product
                ST_VIS: begin
                    if (term_reg == 2'd2) begin
                        z_reg[1]  <= vis_reg[1][kpf_pkg::POS_W-1] ? -q_vis : q_vis;
                        job_reg   <= J_DET;
                        term_reg  <= 2'd0;
                        state_reg <= ST_MAC;
                    end else begin
                        term_reg <= term_reg + 2'd1;
                        if (term_reg == 2'd1) begin
                            z_reg[0] <= vis_reg[0][kpf_pkg::POS_W-1] ? -q_vis : q_vis;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        k_reg[job_reg[1:0]] <= neg_reg ? -q_cov : q_cov;
                        term_reg <= 2'd0;
                        if (job_reg == J_K3) begin
                            state_reg <= ST_INN;
                        end else begin
                            job_reg   <= job_t'(job_reg + 4'd1);
                            state_reg <= ST_MAC;
                        end
                    end
                end
                ST_MAC: begin
                    term_reg <= term_reg + 2'd1;
                    if (term_reg == 2'd1) begin
                        acc_reg <= prod;
                    end else if (term_reg == 2'd2) begin
                        acc_reg   <= (job_reg == J_DET) ? acc_reg - prod : acc_reg + prod;
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    term_reg <= 2'd0;
                    case (job_reg)
                        J_DET: begin
                            detf_reg <= detf_w;
                            if (detf_w == '0) begin
                                sing_reg  <= 1'b1;
                                state_reg <= ST_OUT;
                            end else begin
                                sing_reg  <= 1'b0;
                                job_reg   <= J_K0;
                                state_reg <= ST_MAC;
                            end
                        end
                        J_K0, J_K1, J_K2, J_K3: begin
                            neg_reg <= acc_reg[kpf_pkg::ACC_W-1] ^ detf_reg[kpf_pkg::DVS_W-1];
                            div_req_reg.dividend <= acc_mag
                                + kpf_pkg::DVD_W'(det_mag >> 1);
                            div_req_reg.divisor  <= det_mag;
                            state_reg <= ST_DIV;
                        end
                        J_C0, J_C1: begin
                            fx_reg[job_reg[0]] <= kpf_pkg::sat_pos(
                                kpf_pkg::acc_t'(pred_reg[job_reg[0]]) + rnd_w);
                            job_reg   <= (job_reg == J_C0) ? J_C1 : J_P0;
                            state_reg <= ST_MAC;
                        end
                        default: begin
                            pn_reg[job_reg[1:0]] <= kpf_pkg::sat_cov(
                                kpf_pkg::acc_t'(pp_reg[job_reg[1:0]]) - rnd_w);
                            if (job_reg == J_P3) begin
                                state_reg <= ST_OUT;
                            end else begin
                                job_reg   <= job_t'(job_reg + 4'd1);
                                state_reg <= ST_MAC;
                            end
                        end
                    endcase
                end
                ST_INN: begin
                    inn_reg[0] <= kpf_pkg::sat_pos_sym(kpf_pkg::acc_t'(z_reg[0])
                                  - kpf_pkg::acc_t'(pred_reg[0]));
                    inn_reg[1] <= kpf_pkg::sat_pos_sym(kpf_pkg::acc_t'(z_reg[1])
                                  - kpf_pkg::acc_t'(pred_reg[1]));
                    job_reg    <= J_C0;
                    term_reg   <= 2'd0;
                    state_reg  <= ST_MAC;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        if (sing_reg) begin
                            out_reg.fused_x  <= est_reg[0];
                            out_reg.fused_y  <= est_reg[1];
                            out_reg.singular <= 1'b1;
                        end else begin
                            out_reg.fused_x  <= fx_reg[0];
                            out_reg.fused_y  <= fx_reg[1];
                            out_reg.singular <= 1'b0;
                            est_reg[0]       <= fx_reg[0];
                            est_reg[1]       <= fx_reg[1];
                            cov_reg[0]       <= pn_reg[0];
                            cov_reg[1]       <= pn_reg[1];
                            cov_reg[2]       <= pn_reg[2];
                            cov_reg[3]       <= pn_reg[3];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

endmodule
